[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/wdcg_pkg.sv]
package wdcg_pkg;

	// Port widths
	localparam int ANGLE_W    = 13;
	localparam int COUNT_W    = 16;
	localparam int CODE_W     = 16;
	localparam int MODE_W     = 3;
	localparam int THR_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int ANGLE_FRAC_BITS_DEF = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_PEAK     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_GAIN     = 2'd3;

	// Reset values
	localparam logic [MODE_W-1:0]  WAVE_MODE_RST     = 3'd0;
	localparam logic [THR_W-1:0]   PWM_THRESHOLD_RST = 9'd180;
	localparam logic [COUNT_W-1:0] CLIP_PEAK_RST     = 16'd4095;
	localparam logic [COUNT_W-1:0] RAMP_GAIN_RST     = 16'd1;

	// Wave modes
	localparam logic [MODE_W-1:0] MODE_SINE     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POS_HALF = 3'd1;
	localparam logic [MODE_W-1:0] MODE_NEG_HALF = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SQUARE   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_STEP3    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_PWM      = 3'd5;
	localparam logic [MODE_W-1:0] MODE_CLIP     = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RAMP     = 3'd7;

	// Quadrant codes
	localparam logic [1:0] QUAD_1 = 2'd0;
	localparam logic [1:0] QUAD_2 = 2'd1;
	localparam logic [1:0] QUAD_3 = 2'd2;
	localparam logic [1:0] QUAD_4 = 2'd3;

	// Integer angle breakpoints (degrees)
	localparam int DEG_90  = 90;
	localparam int DEG_180 = 180;
	localparam int DEG_270 = 270;
	localparam int DEG_360 = 360;

	// DAC levels
	localparam logic [11:0] DAC_MID  = 12'd2047;
	localparam logic [11:0] DAC_MAX  = 12'd4095;
	localparam logic [11:0] DAC_ZERO = 12'd0;

	// Q30 sine arithmetic
	localparam int Q_FRAC = 30;
	localparam int XW     = 31;   // radian angle, below pi/2
	localparam int X2W    = 32;   // x squared, below 2.5
	localparam int TW     = 31;   // Horner term, at most 1.0
	localparam int SW     = 32;   // raw sine product
	localparam logic [TW-1:0] Q30_ONE = 31'h4000_0000;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	localparam int HORNER_STEPS = 5;
	localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{110, 72, 42, 20, 6};

	// Magnitude: 2047 * s >> 22, i.e. 11 integer and 8 fraction bits
	localparam logic [10:0] SINE_AMP  = 11'd2047;
	localparam int MAG_SHIFT = 22;
	localparam int MAG_W     = 19;
	localparam int MAG_FRAC  = 8;
	localparam logic [MAG_W-1:0] MAG_MAX   = 19'd524032;
	localparam logic [MAG_W:0]   MAG_ROUND = 20'd255;

	// Output skid depth
	localparam logic [1:0] SKID_FULL = 2'd2;
	localparam logic [1:0] SKID_EMPTY = 2'd0;

	// Per-item sideband that rides along the sine pipeline
	typedef struct packed {
		logic [1:0]        quad;
		logic              use_sine;
		logic [CODE_W-1:0] alt;
	} side_t;

	// Horner pipeline context
	typedef struct packed {
		logic [XW-1:0]  x;
		logic [X2W-1:0] x2;
		logic           zero;
		logic           full;
		side_t          side;
	} hctx_t;

endpackage

[hw/rtl/wdcg_cdiv.sv]
// Registered divide by a constant: multiply by a rounded-up reciprocal and shift.
// Exact for every W-bit input.
module wdcg_cdiv #(
	parameter int W = 32,
	parameter int C = 3,
	localparam int QW = W - $clog2(C) + 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  n,
	output logic [QW-1:0] q
);

	localparam int K  = $clog2(C);
	localparam int MW = W + 2;
	localparam longint unsigned RECIP = ((64'd1 << (W + K)) + longint'(C) - 64'd1) / longint'(C);
	localparam logic [MW-1:0] RECIP_V = RECIP[MW-1:0];

	logic [W+MW-1:0] prod;

	assign prod = (W + MW)'(n) * (W + MW)'(RECIP_V);

	// quotient register
	always_ff @(posedge clk) begin
		if (en) begin
			q <= prod[W+K +: QW];
		end
	end

endmodule

[hw/rtl/wdcg_hstep.sv]
// One Horner step: t' = 1 - floor(floor(x2 * t / 2^30) / DIV), two stages.
module wdcg_hstep #(
	parameter int DIV = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  wdcg_pkg::hctx_t           in_ctx,
	input  logic [wdcg_pkg::TW-1:0]   in_t,
	output logic                      out_valid,
	output wdcg_pkg::hctx_t           out_ctx,
	output logic [wdcg_pkg::TW-1:0]   out_t
);

	localparam int PW = wdcg_pkg::X2W + wdcg_pkg::TW;
	localparam int QW = wdcg_pkg::X2W - $clog2(DIV) + 1;

	logic [PW-1:0]               prod;
	logic [wdcg_pkg::X2W-1:0]    p_s1;
	logic [QW-1:0]               q_s2;
	wdcg_pkg::hctx_t             ctx_s1;
	wdcg_pkg::hctx_t             ctx_s2;
	logic                        v_s1;
	logic                        v_s2;

	assign prod = PW'(in_ctx.x2) * PW'(in_t);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// product and context
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1   <= prod[wdcg_pkg::Q_FRAC +: wdcg_pkg::X2W];
			ctx_s1 <= in_ctx;
			ctx_s2 <= ctx_s1;
		end
	end

	wdcg_cdiv #(
		.W (wdcg_pkg::X2W),
		.C (DIV)
	) u_div (
		.clk (clk),
		.en  (en),
		.n   (p_s1),
		.q   (q_s2)
	);

	assign out_valid = v_s2;
	assign out_ctx   = ctx_s2;
	assign out_t     = wdcg_pkg::Q30_ONE - wdcg_pkg::TW'(q_s2);

endmodule

[hw/rtl/wdcg_sine_mag.sv]
// Sine magnitude pipeline: reference angle in, 2047*|sin| with 8 fraction bits out.
// Stages: radians (3), square (1), Horner (10), product (1), scale (1).
module wdcg_sine_mag #(
	parameter int ANGLE_FRAC_BITS = wdcg_pkg::ANGLE_FRAC_BITS_DEF,
	localparam int RW = $clog2(90 * (1 << ANGLE_FRAC_BITS) + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [RW-1:0]               in_r,
	input  wdcg_pkg::side_t             in_side,
	output logic                        out_valid,
	output logic [wdcg_pkg::MAG_W-1:0]  out_mag,
	output wdcg_pkg::side_t             out_side
);

	localparam int D     = 1 << ANGLE_FRAC_BITS;
	localparam int R_MAX = 90 * D;
	localparam int C180  = 180 * D;
	// r*pi/(180D) = r*QP + r*RP/(180D)
	localparam longint unsigned QP = wdcg_pkg::PI_Q30 / C180;
	localparam longint unsigned RP = wdcg_pkg::PI_Q30 % C180;
	localparam int QPW = $clog2(QP + 1);
	localparam int RPW = $clog2(C180);
	localparam int HW  = RW + QPW;
	localparam int LW  = RW + RPW;
	localparam int FQW = LW - $clog2(C180) + 1;
	localparam logic [QPW-1:0] QP_V = QP[QPW-1:0];
	localparam logic [RPW-1:0] RP_V = RP[RPW-1:0];
	localparam int XPW = 2 * wdcg_pkg::XW;
	localparam int SPW = wdcg_pkg::XW + wdcg_pkg::TW;
	localparam int MPW = 11 + wdcg_pkg::TW;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [HW-1:0]            hi_s1, hi_s2;
	logic [LW-1:0]            lo_s1;
	logic [FQW-1:0]           fq_s2;
	logic [wdcg_pkg::XW-1:0]  x_s3, x_s4;
	logic [wdcg_pkg::X2W-1:0] x2_s4;
	logic                     zero_s1, zero_s2, zero_s3, zero_s4, zero_s5;
	logic                     full_s1, full_s2, full_s3, full_s4, full_s5;
	wdcg_pkg::side_t          side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [XPW-1:0]           xsq;
	logic [SPW-1:0]           sprod;
	logic [wdcg_pkg::SW-1:0]  s_s5;
	logic [wdcg_pkg::TW-1:0]  s_cap;
	logic [MPW-1:0]           mprod;
	logic [wdcg_pkg::MAG_W-1:0] mag_s6;

	wdcg_pkg::hctx_t          ctx_h [wdcg_pkg::HORNER_STEPS+1];
	logic [wdcg_pkg::TW-1:0]  t_h   [wdcg_pkg::HORNER_STEPS+1];
	logic                     v_h   [wdcg_pkg::HORNER_STEPS+1];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_h[wdcg_pkg::HORNER_STEPS];
			v_s6 <= v_s5;
		end
	end

	// radians: integer and remainder parts of r*pi/(180D), then the square
	assign xsq = XPW'(x_s3) * XPW'(x_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1   <= HW'(in_r) * HW'(QP_V);
			lo_s1   <= LW'(in_r) * LW'(RP_V);
			zero_s1 <= (in_r == '0);
			full_s1 <= (in_r == RW'(R_MAX));
			side_s1 <= in_side;

			hi_s2   <= hi_s1;
			zero_s2 <= zero_s1;
			full_s2 <= full_s1;
			side_s2 <= side_s1;

			x_s3    <= wdcg_pkg::XW'(hi_s2) + wdcg_pkg::XW'(fq_s2);
			zero_s3 <= zero_s2;
			full_s3 <= full_s2;
			side_s3 <= side_s2;

			x_s4    <= x_s3;
			x2_s4   <= xsq[wdcg_pkg::Q_FRAC +: wdcg_pkg::X2W];
			zero_s4 <= zero_s3;
			full_s4 <= full_s3;
			side_s4 <= side_s3;
		end
	end

	wdcg_cdiv #(
		.W (LW),
		.C (C180)
	) u_frac_div (
		.clk (clk),
		.en  (en),
		.n   (lo_s1),
		.q   (fq_s2)
	);

	// Horner chain
	assign ctx_h[0] = '{x: x_s4, x2: x2_s4, zero: zero_s4, full: full_s4, side: side_s4};
	assign t_h[0]   = wdcg_pkg::Q30_ONE;
	assign v_h[0]   = v_s4;

	for (genvar g = 0; g < wdcg_pkg::HORNER_STEPS; g++) begin : g_horner
		wdcg_hstep #(
			.DIV (int'(wdcg_pkg::HORNER_DIV[g]))
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_h[g]),
			.in_ctx    (ctx_h[g]),
			.in_t      (t_h[g]),
			.out_valid (v_h[g+1]),
			.out_ctx   (ctx_h[g+1]),
			.out_t     (t_h[g+1])
		);
	end

	// s = x*t, then cap and special angles, then scale to 2047
	assign sprod = SPW'(ctx_h[wdcg_pkg::HORNER_STEPS].x) * SPW'(t_h[wdcg_pkg::HORNER_STEPS]);

	always_comb begin
		if (full_s5) begin
			s_cap = wdcg_pkg::Q30_ONE;
		end else if (zero_s5) begin
			s_cap = '0;
		end else if (s_s5 > wdcg_pkg::SW'(wdcg_pkg::Q30_ONE)) begin
			s_cap = wdcg_pkg::Q30_ONE;
		end else begin
			s_cap = s_s5[wdcg_pkg::TW-1:0];
		end
	end

	assign mprod = MPW'(wdcg_pkg::SINE_AMP) * MPW'(s_cap);

	always_ff @(posedge clk) begin
		if (en) begin
			s_s5    <= sprod[wdcg_pkg::Q_FRAC +: wdcg_pkg::SW];
			zero_s5 <= ctx_h[wdcg_pkg::HORNER_STEPS].zero;
			full_s5 <= ctx_h[wdcg_pkg::HORNER_STEPS].full;
			side_s5 <= ctx_h[wdcg_pkg::HORNER_STEPS].side;

			mag_s6  <= mprod[wdcg_pkg::MAG_SHIFT +: wdcg_pkg::MAG_W];
			side_s6 <= side_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_mag   = mag_s6;
	assign out_side  = side_s6;

endmodule

[hw/rtl/waveform_dac_code_generator.sv]
// Waveform DAC code generator.
// Input channel (in_valid/in_ready): one request per item with angle_q4, the
// phase in 2^-ANGLE_FRAC_BITS degree steps, and count, a signed sample count.
// Output channel (out_valid/out_ready): one 16-bit code per request, in order.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// 0 wave mode, 1 pwm threshold, 2 clip peak, 3 ramp gain. Write only when idle.
// Throughput: one request per cycle, set by the fully pipelined sine path
// (decode, three radian stages, square, five two-stage Horner steps, product,
// scale), which every request walks through whatever the mode.
// A request passes stage 1, the sine pipeline and the buffer to out_valid.
// Results land in a two-entry output buffer; the pipeline advances while the
// buffer has room, so a request is still taken while one result waits.
// When the receiver stalls and the buffer fills, in_ready drops and the
// whole pipeline holds; nothing is dropped or repeated.
// Reset clears all valid bits and the buffer and loads the register defaults:
// sine mode, threshold 180, clip peak 4095, ramp gain 1.
module waveform_dac_code_generator #(
	parameter int ANGLE_FRAC_BITS = wdcg_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [wdcg_pkg::ANGLE_W-1:0]      angle_q4,
	input  logic signed [wdcg_pkg::COUNT_W-1:0] count,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [wdcg_pkg::CODE_W-1:0] code,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wdcg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wdcg_pkg::CFG_DATA_W-1:0]   cfg_data
);

`include "assert_macros.svh"

	localparam int D    = 1 << ANGLE_FRAC_BITS;
	localparam int A90  = 90 * D;
	localparam int A180 = 180 * D;
	localparam int A270 = 270 * D;
	localparam int A360 = 360 * D;
	localparam int AW0  = $clog2(A360 + 1);
	localparam int AW   = (AW0 > wdcg_pkg::ANGLE_W) ? AW0 : wdcg_pkg::ANGLE_W;
	localparam int RW   = $clog2(A90 + 1);
	localparam int CW   = wdcg_pkg::CODE_W;

	// configuration registers
	logic [wdcg_pkg::MODE_W-1:0]        wave_mode_q;
	logic [wdcg_pkg::THR_W-1:0]         pwm_threshold_q;
	logic signed [wdcg_pkg::COUNT_W-1:0] clip_peak_q;
	logic signed [wdcg_pkg::COUNT_W-1:0] ramp_gain_q;

	logic                 en;
	logic [AW-1:0]        ang_ext, ang_c, ai, r_full;
	logic [1:0]           quad;
	logic signed [2*wdcg_pkg::COUNT_W-1:0] ramp_prod;
	logic [CW-1:0]        clip_res;
	wdcg_pkg::side_t      side_d;

	logic                 v_s1;
	logic [RW-1:0]        r_s1;
	wdcg_pkg::side_t      side_s1;

	logic                       mag_valid;
	logic [wdcg_pkg::MAG_W-1:0] mag;
	wdcg_pkg::side_t            mag_side;
	logic [wdcg_pkg::MAG_W:0]   mag_rnd;
	logic [11:0]                sine12;
	logic [CW-1:0]              res_code;

	logic [1:0]     skid_cnt_q;
	logic [CW-1:0]  e0_q, e1_q;
	logic           push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q     <= wdcg_pkg::WAVE_MODE_RST;
			pwm_threshold_q <= wdcg_pkg::PWM_THRESHOLD_RST;
			clip_peak_q     <= wdcg_pkg::CLIP_PEAK_RST;
			ramp_gain_q     <= wdcg_pkg::RAMP_GAIN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				wdcg_pkg::REG_WAVE_MODE:     wave_mode_q     <= cfg_data[wdcg_pkg::MODE_W-1:0];
				wdcg_pkg::REG_PWM_THRESHOLD: pwm_threshold_q <= cfg_data[wdcg_pkg::THR_W-1:0];
				wdcg_pkg::REG_CLIP_PEAK:     clip_peak_q     <= cfg_data;
				wdcg_pkg::REG_RAMP_GAIN:     ramp_gain_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advances while the output buffer has room
	assign en       = (skid_cnt_q != wdcg_pkg::SKID_FULL);
	assign in_ready = en;

	// angle hold, quadrant and reference angle
	always_comb begin
		ang_ext = AW'(angle_q4);
		ang_c   = (ang_ext > AW'(A360)) ? AW'(A360) : ang_ext;
		ai      = ang_c >> ANGLE_FRAC_BITS;
		if (ang_c <= AW'(A90)) begin
			quad = wdcg_pkg::QUAD_1;
		end else if (ang_c <= AW'(A180)) begin
			quad = wdcg_pkg::QUAD_2;
		end else if (ang_c <= AW'(A270)) begin
			quad = wdcg_pkg::QUAD_3;
		end else begin
			quad = wdcg_pkg::QUAD_4;
		end
		case (quad)
			wdcg_pkg::QUAD_1: r_full = ang_c;
			wdcg_pkg::QUAD_2: r_full = AW'(A180) - ang_c;
			wdcg_pkg::QUAD_3: r_full = ang_c - AW'(A180);
			default:          r_full = AW'(A360) - ang_c;
		endcase
	end

	// count-based modes
	assign ramp_prod = count * ramp_gain_q;
	assign clip_res  = (count > clip_peak_q) ? CW'(clip_peak_q - 16'sd1) : CW'(count);

	// mode decode: either the sine path or a directly computed code
	always_comb begin
		side_d.quad     = quad;
		side_d.use_sine = 1'b0;
		side_d.alt      = '0;
		case (wave_mode_q)
			wdcg_pkg::MODE_SINE: begin
				side_d.use_sine = 1'b1;
			end
			wdcg_pkg::MODE_POS_HALF: begin
				side_d.use_sine = (quad == wdcg_pkg::QUAD_1) || (quad == wdcg_pkg::QUAD_3);
				side_d.alt      = CW'(wdcg_pkg::DAC_MID);
			end
			wdcg_pkg::MODE_NEG_HALF: begin
				side_d.use_sine = (quad == wdcg_pkg::QUAD_2) || (quad == wdcg_pkg::QUAD_4);
				side_d.alt      = CW'(wdcg_pkg::DAC_MID);
			end
			wdcg_pkg::MODE_SQUARE: begin
				side_d.alt = (ai <= AW'(wdcg_pkg::DEG_180)) ? CW'(wdcg_pkg::DAC_MAX)
					: CW'(wdcg_pkg::DAC_ZERO);
			end
			wdcg_pkg::MODE_STEP3: begin
				if (ai <= AW'(wdcg_pkg::DEG_90)) begin
					side_d.alt = CW'(wdcg_pkg::DAC_MAX);
				end else if (ai <= AW'(wdcg_pkg::DEG_180)) begin
					side_d.alt = CW'(wdcg_pkg::DAC_MID);
				end else if (ai <= AW'(wdcg_pkg::DEG_270)) begin
					side_d.alt = CW'(wdcg_pkg::DAC_ZERO);
				end else begin
					side_d.alt = CW'(wdcg_pkg::DAC_MID);
				end
			end
			wdcg_pkg::MODE_PWM: begin
				side_d.alt = (ai <= AW'(pwm_threshold_q)) ? CW'(wdcg_pkg::DAC_MAX)
					: CW'(wdcg_pkg::DAC_ZERO);
			end
			wdcg_pkg::MODE_CLIP: begin
				side_d.alt = clip_res;
			end
			wdcg_pkg::MODE_RAMP: begin
				side_d.alt = ramp_prod[CW-1:0];
			end
			default: begin
				side_d.alt = '0;
			end
		endcase
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= r_full[RW-1:0];
			side_s1 <= side_d;
		end
	end

	wdcg_sine_mag #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_sine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_r      (r_s1),
		.in_side   (side_s1),
		.out_valid (mag_valid),
		.out_mag   (mag),
		.out_side  (mag_side)
	);

	// sine code: truncate upward half, round magnitude up on the lower half
	assign mag_rnd = {1'b0, mag} + wdcg_pkg::MAG_ROUND;

	always_comb begin
		if ((mag_side.quad == wdcg_pkg::QUAD_1) || (mag_side.quad == wdcg_pkg::QUAD_2)) begin
			sine12 = wdcg_pkg::DAC_MID + 12'(mag[wdcg_pkg::MAG_W-1:wdcg_pkg::MAG_FRAC]);
		end else begin
			sine12 = wdcg_pkg::DAC_MID - 12'(mag_rnd[wdcg_pkg::MAG_W:wdcg_pkg::MAG_FRAC]);
		end
		res_code = mag_side.use_sine ? CW'(sine12) : mag_side.alt;
	end

	// two-entry output buffer
	assign push = mag_valid && en;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_cnt_q <= wdcg_pkg::SKID_EMPTY;
		end else begin
			skid_cnt_q <= skid_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (skid_cnt_q == wdcg_pkg::SKID_EMPTY) begin
			if (push) begin
				e0_q <= res_code;
			end
		end else if (skid_cnt_q == wdcg_pkg::SKID_FULL) begin
			if (pop) begin
				e0_q <= e1_q;
			end
		end else begin
			if (push && pop) begin
				e0_q <= res_code;
			end else if (push) begin
				e1_q <= res_code;
			end
		end
	end

	assign out_valid = (skid_cnt_q != wdcg_pkg::SKID_EMPTY);
	assign code      = e0_q;

	// checks
	`ASSERT_NEXT(a_in_to_s1, clk, arst_n, in_valid && in_ready, v_s1, "accepted request lost at stage 1")
	`ASSERT_NEXT(a_skid_step, clk, arst_n, skid_cnt_q == wdcg_pkg::SKID_EMPTY, skid_cnt_q != wdcg_pkg::SKID_FULL, "output buffer grew by two in one cycle")
	`ASSERT_IMPLIES(a_mag_range, clk, arst_n, mag_valid, mag <= wdcg_pkg::MAG_MAX, "sine magnitude above full scale")

endmodule

[verif/wdcg_code_monitor.sv]
// Code monitor: watches the request, result and register channels of the
// waveform DAC code generator, predicts each code and compares in order.
module wdcg_code_monitor #(
	parameter int FRAC = wdcg_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [wdcg_pkg::ANGLE_W-1:0]        angle_q4,
	input  logic signed [wdcg_pkg::COUNT_W-1:0] count,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [wdcg_pkg::CODE_W-1:0]  code,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [wdcg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wdcg_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                  mismatches,
	output int                                  outstanding,
	output int                                  checked
);
	import wdcg_pkg::*;

	localparam int UNIT = 1 << FRAC;
	localparam longint unsigned ONE_FIX = 64'd1 << 30;
	localparam longint unsigned PI_FIX  = 64'd3373259426;

	// Shadow copy of the register file
	logic [MODE_W-1:0]         mode_r;
	logic [THR_W-1:0]          thr_r;
	logic signed [COUNT_W-1:0] peak_r;
	logic signed [COUNT_W-1:0] gain_r;

	logic [CODE_W-1:0] expected_codes [$];
	logic [CODE_W-1:0] want;

	// |sin(r)| scaled by 2047, 8 fraction bits; r in angle units, 0..90 deg
	function automatic longint unsigned sine_magnitude(input int unsigned r);
		longint unsigned x, x2, t, s, dv;
		int k;
		if (r == 0)
			return 0;
		if (r >= 90 * UNIT) begin
			s = ONE_FIX;
		end else begin
			x  = (64'(r) * PI_FIX) / 64'(180 * UNIT);
			x2 = (x * x) >> 30;
			t  = ONE_FIX;
			// Horner over the Taylor terms, divisors 11*10 down to 3*2
			for (k = 0; k < 5; k++) begin
				dv = 64'((10 - 2 * k) * (11 - 2 * k));
				t  = ONE_FIX - ((x2 * t) >> 30) / dv;
			end
			s = (x * t) >> 30;
			if (s > ONE_FIX)
				s = ONE_FIX;
		end
		return (64'd2047 * s) >> 22;
	endfunction

	// Full sine DAC level for a held angle in a given quadrant
	function automatic logic [CODE_W-1:0] sine_level(input int unsigned a, input logic [1:0] q);
		int unsigned r;
		longint unsigned m;
		case (q)
			QUAD_1:  r = a;
			QUAD_2:  r = 180 * UNIT - a;
			QUAD_3:  r = a - 180 * UNIT;
			default: r = 360 * UNIT - a;
		endcase
		m = sine_magnitude(r);
		// upper half truncates the fraction, lower half rounds it away
		if (q == QUAD_1 || q == QUAD_2)
			return CODE_W'(64'(DAC_MID) + (m >> 8));
		return CODE_W'(64'(DAC_MID) - ((m + 255) >> 8));
	endfunction

	function automatic logic [CODE_W-1:0] predict_dac_code(input logic [ANGLE_W-1:0] ang,
			input logic signed [COUNT_W-1:0] cnt);
		int unsigned a, deg;
		logic [1:0] q;
		int prod;
		logic [CODE_W-1:0] res;
		// angles past a full turn are held at 360 degrees
		a   = (ang > 360 * UNIT) ? 360 * UNIT : ang;
		deg = a >> FRAC;
		if (a <= 90 * UNIT)
			q = QUAD_1;
		else if (a <= 180 * UNIT)
			q = QUAD_2;
		else if (a <= 270 * UNIT)
			q = QUAD_3;
		else
			q = QUAD_4;
		case (mode_r)
			MODE_SINE:     res = sine_level(a, q);
			MODE_POS_HALF: res = (q == QUAD_1 || q == QUAD_3) ? sine_level(a, q) : CODE_W'(DAC_MID);
			MODE_NEG_HALF: res = (q == QUAD_2 || q == QUAD_4) ? sine_level(a, q) : CODE_W'(DAC_MID);
			MODE_SQUARE:   res = (deg <= DEG_180) ? CODE_W'(DAC_MAX) : CODE_W'(DAC_ZERO);
			MODE_STEP3: begin
				if (deg <= DEG_90)
					res = CODE_W'(DAC_MAX);
				else if (deg <= DEG_180)
					res = CODE_W'(DAC_MID);
				else if (deg <= DEG_270)
					res = CODE_W'(DAC_ZERO);
				else
					res = CODE_W'(DAC_MID);
			end
			MODE_PWM:      res = (deg <= thr_r) ? CODE_W'(DAC_MAX) : CODE_W'(DAC_ZERO);
			MODE_CLIP: begin
				prod = (cnt > peak_r) ? int'(peak_r) - 1 : int'(cnt);
				res  = prod[CODE_W-1:0];
			end
			default: begin
				prod = int'(cnt) * int'(gain_r);
				res  = prod[CODE_W-1:0];
			end
		endcase
		return res;
	endfunction

	// Track register writes, queue predictions, compare results in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_r      <= WAVE_MODE_RST;
			thr_r       <= PWM_THRESHOLD_RST;
			peak_r      <= CLIP_PEAK_RST;
			gain_r      <= RAMP_GAIN_RST;
			expected_codes.delete();
			mismatches  <= 0;
			outstanding <= 0;
			checked     <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WAVE_MODE:     mode_r <= cfg_data[MODE_W-1:0];
					REG_PWM_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
					REG_CLIP_PEAK:     peak_r <= cfg_data;
					REG_RAMP_GAIN:     gain_r <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_codes.size() == 0) begin
					$display("%0t ERROR: code %0d with no request pending", $time, code);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_codes.pop_front();
					checked <= checked + 1;
					if (code !== want) begin
						$display("%0t ERROR: code mismatch, expected %0d, got %0d",
							$time, $signed(want), code);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (in_valid && in_ready)
				expected_codes.push_back(predict_dac_code(angle_q4, count));
			outstanding <= expected_codes.size();
		end
	end

endmodule

[verif/waveform_dac_code_generator_tb.sv]
module waveform_dac_code_generator_tb;
	import wdcg_pkg::*;

	localparam int UNIT         = 1 << ANGLE_FRAC_BITS_DEF;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASES       = 16;
	localparam int PHASE_ITEMS  = 62;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [ANGLE_W-1:0]      angle_q4;
	logic signed [COUNT_W-1:0] count;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [CODE_W-1:0] code;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	int mismatches, outstanding, checked;

	// Stimulus control shared with the result side
	logic calm      = 1'b0;
	int   hold_req  = 0;
	int   hold_seen = 0;
	int   hold_left = 0;

	logic [MODE_W-1:0]         cur_mode = MODE_SINE;
	logic [THR_W-1:0]          cur_thr  = PWM_THRESHOLD_RST;
	logic signed [COUNT_W-1:0] cur_peak = CLIP_PEAK_RST;
	int items_by_mode [8];
	int settings = 0;

	waveform_dac_code_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.angle_q4  (angle_q4),
		.count     (count),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.code      (code),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	wdcg_code_monitor u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.angle_q4    (angle_q4),
		.count       (count),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code        (code),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked)
	);

	// 10-unit clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Result side: random back-pressure plus the long hold-off on demand
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99, 0) >= 24);
		end
	end

	// Handshakes are sampled at the falling edge, where inputs are settled
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		logic ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
	endtask

	// Stop offering and wait until every predicted code has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic [MODE_W-1:0] m, input logic [THR_W-1:0] thr,
			input logic [CFG_DATA_W-1:0] peak, input logic [CFG_DATA_W-1:0] gain);
		logic [31:0] junk;
		drain();
		junk = $urandom;
		// unused upper data bits carry noise
		write_reg(REG_WAVE_MODE, {junk[12:0], m});
		write_reg(REG_PWM_THRESHOLD, {junk[31:25], thr});
		write_reg(REG_CLIP_PEAK, peak);
		write_reg(REG_RAMP_GAIN, gain);
		cfg_valid <= 1'b0;
		cur_mode = m;
		cur_thr  = thr;
		cur_peak = peak;
		settings++;
	endtask

	task automatic send_item(input logic [ANGLE_W-1:0] a, input logic [COUNT_W-1:0] c);
		logic ok;
		while (!calm && $urandom_range(99, 0) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		angle_q4 <= a;
		count    <= c;
		do begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end while (!ok);
		items_by_mode[cur_mode]++;
	endtask

	// Mostly in-range angles, some clustered on quadrant and degree edges, some held
	function automatic logic [ANGLE_W-1:0] pick_angle();
		int sel, deg, a;
		logic [ANGLE_W-1:0] v;
		sel = $urandom_range(99, 0);
		if (sel < 10) begin
			a = $urandom_range(8191, 360 * UNIT + 1);
		end else if (sel < 35) begin
			case ($urandom_range(5, 0))
				0:       deg = 0;
				1:       deg = DEG_90;
				2:       deg = DEG_180;
				3:       deg = DEG_270;
				4:       deg = DEG_360;
				default: deg = cur_thr;
			endcase
			a = deg * UNIT + ($urandom_range(1, 0) ? UNIT : 0) + int'($urandom_range(4, 0)) - 2;
			if (a < 0)
				a = 0;
			if (a > 8191)
				a = 8191;
		end else begin
			a = $urandom_range(360 * UNIT, 0);
		end
		v = a[ANGLE_W-1:0];
		return v;
	endfunction

	// Counts: extremes, values around the clip peak, or anything
	function automatic logic [COUNT_W-1:0] pick_count();
		int sel, c;
		sel = $urandom_range(99, 0);
		if (sel < 10) begin
			case ($urandom_range(3, 0))
				0:       c = -32768;
				1:       c = 32767;
				2:       c = 0;
				default: c = -1;
			endcase
		end else if (sel < 35) begin
			c = int'(cur_peak) + int'($urandom_range(4, 0)) - 2;
		end else begin
			c = $urandom;
		end
		return c[COUNT_W-1:0];
	endfunction

	// Stimulus
	initial begin
		int sine_marks [12];
		int p, i;
		logic [MODE_W-1:0] m;
		logic [THR_W-1:0] thr;
		logic [CFG_DATA_W-1:0] peak, gain;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		angle_q4  = '0;
		count     = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_WAVE_MODE;
		cfg_data  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero crossings, peaks, quadrant edges, held angles
		sine_marks = '{0, 1439, 1440, 1441, 2880, 2881, 4320, 4321, 5759, 5760, 5761, 8191};
		set_regs(MODE_SINE, 9'd180, 16'd4095, 16'd1);
		foreach (sine_marks[k])
			send_item(sine_marks[k], (k % 2) ? 16'h8000 : 16'h7fff);
		set_regs(MODE_POS_HALF, 9'd180, 16'd4095, 16'd1);
		send_item(13'd2000, 16'h0000);
		set_regs(MODE_NEG_HALF, 9'd180, 16'd4095, 16'd1);
		send_item(13'd5000, 16'h0000);
		set_regs(MODE_SQUARE, 9'd180, 16'd4095, 16'd1);
		send_item(13'd2895, 16'h0000);
		send_item(13'd2896, 16'h0000);
		set_regs(MODE_STEP3, 9'd180, 16'd4095, 16'd1);
		send_item(13'd1455, 16'h0000);
		send_item(13'd4336, 16'h0000);
		set_regs(MODE_PWM, 9'd0, 16'd4095, 16'd1);
		send_item(13'd15, 16'h0000);
		send_item(13'd16, 16'h0000);
		// clip peak at the negative extreme wraps peak minus one
		set_regs(MODE_CLIP, 9'd180, 16'h8000, 16'd1);
		send_item(13'd0, 16'h7fff);
		send_item(13'd0, 16'h8000);
		set_regs(MODE_RAMP, 9'd180, 16'd4095, 16'h8000);
		send_item(13'd0, 16'h8000);
		send_item(13'd0, 16'h7fff);

		// Random phases: first pass with extreme registers, second with random ones
		for (p = 0; p < PHASES; p++) begin
			m = p[MODE_W-1:0];
			if (p < 8) begin
				case (p % 3)
					0:       thr = 9'd0;
					1:       thr = 9'd360;
					default: thr = 9'd511;
				endcase
				case ((p + 1) % 3)
					0:       peak = 16'h8000;
					1:       peak = 16'h7fff;
					default: peak = 16'h0000;
				endcase
				case ((p + 1) % 4)
					0:       gain = 16'h8000;
					1:       gain = 16'h7fff;
					2:       gain = 16'hffff;
					default: gain = 16'h0000;
				endcase
			end else begin
				thr  = $urandom_range(511, 0);
				peak = $urandom;
				gain = $urandom;
			end
			set_regs(m, thr, peak, gain);
			if (p == 3)
				calm <= 1'b1;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				// long receiver hold-off while requests keep coming
				if (p == 5 && i == 10)
					hold_req <= hold_req + 1;
				// sender pause until the pipeline is empty
				if (p == 10 && i == 30)
					drain();
				send_item(pick_angle(), pick_count());
			end
			if (p == 3)
				calm <= 1'b0;
		end

		drain();
		$display("Covered %0d codes checked over %0d register settings, all eight modes.",
			checked, settings);
		$display("Requests per mode (sine..ramp): %0d %0d %0d %0d %0d %0d %0d %0d",
			items_by_mode[0], items_by_mode[1], items_by_mode[2], items_by_mode[3],
			items_by_mode[4], items_by_mode[5], items_by_mode[6], items_by_mode[7]);
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
